// ----- rtl/ssa_pkg.sv -----
// shared types for the summary statistics accumulator
package ssa_pkg;

  // controller to datapath commands
  typedef struct packed {
    logic accumulate;   // fold the accepted sample into the running set
    logic snapshot;     // copy the finished set into the back part and clear
    logic mean_start;   // start the mean division
    logic var_start;    // start the variance division
    logic sqrt_start;   // start the square root
  } ssa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
    logic spread_ok;
  } ssa_sts_t;

endpackage

// ----- rtl/ssa_datapath.sv -----
// datapath: running accumulators, serial divider and serial square root
module ssa_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ssa_pkg::ssa_cmd_t             cmd,
  output ssa_pkg::ssa_sts_t             sts,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [COUNT_BITS-1:0]         res_count,
  output logic [SAMPLE_BITS+7:0]        res_mean,
  output logic [SAMPLE_BITS-1:0]        res_min,
  output logic [SAMPLE_BITS-1:0]        res_max,
  output logic [SAMPLE_BITS+7:0]        res_sd,
  output logic                          res_valid,
  output logic                          res_ovf
);

  localparam int SW  = SAMPLE_BITS + COUNT_BITS;        // sum width
  localparam int QW  = 2 * SAMPLE_BITS + COUNT_BITS;    // sum of squares width
  localparam int NW  = QW + COUNT_BITS + 16;            // variance numerator width
  localparam int DW  = 2 * COUNT_BITS;                  // divisor width
  localparam int CW  = $clog2(NW + 1);
  localparam int RW  = SAMPLE_BITS + 8;                 // root width
  localparam int RCW = $clog2(RW + 1);
  localparam int PW  = 2 * RW + 2;                      // root remainder width
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

  // running set
  logic [COUNT_BITS-1:0]         cnt_r;
  logic signed [SW-1:0]          sum_r;
  logic [QW-1:0]                 sq_r;
  logic signed [SAMPLE_BITS-1:0] min_r, max_r;
  logic                          ovf_r;

  logic [SAMPLE_BITS-1:0] mag;
  logic [2*SAMPLE_BITS-1:0] mag_sq;
  assign mag    = sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample) : SAMPLE_BITS'(sample);
  assign mag_sq = mag * mag;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.snapshot) begin
      cnt_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      min_r <= '0;
      max_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.accumulate) begin
      if (cnt_r == '0) begin
        min_r <= sample;
        max_r <= sample;
      end else if (sample < min_r) begin
        min_r <= sample;
      end else if (sample > max_r) begin
        max_r <= sample;
      end
      if (cnt_r == CMAX) begin
        ovf_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + SW'(sample);
        sq_r  <= sq_r + QW'(mag_sq);
      end
    end
  end

  // finished set, held for the back part
  logic [COUNT_BITS-1:0] fcnt_r;
  logic [SW-1:0]         fabs_r;
  logic                  fneg_r;
  logic [QW-1:0]         fsq_r;
  logic [NW-1:0]         num_r;    // count*sumsq, then minus sum^2, shifted
  logic [DW-1:0]         den_r;

  // serial divider, one quotient bit a cycle
  logic [NW-1:0] dn_r, dq_r;
  logic [DW:0]   drem_r;
  logic [DW-1:0] dd_r;
  logic [CW-1:0] dcnt_r;
  logic          dbusy_r, dsel_r;
  logic [DW:0]   dtry;
  assign dtry = {drem_r[DW-1:0], dn_r[NW-1]};

  // serial square root, one result bit a cycle
  logic [RW-1:0]  root_r;
  logic [RCW-1:0] rcnt_r;
  logic           rbusy_r;
  logic [2*RW-1:0] rad_r;
  logic [PW-1:0]  rrem_r, rtrial;
  logic [PW-1:0]  rshift;
  assign rshift = {rrem_r[PW-3:0], rad_r[2*RW-1:2*RW-2]};
  assign rtrial = {(PW-2)'(root_r), 2'b01};

  logic [2*SW-1:0] sum_sq;
  assign sum_sq = fabs_r * fabs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      rbusy_r <= 1'b0;
      dcnt_r  <= '1;
      rcnt_r  <= '1;
      dsel_r  <= 1'b0;
    end else begin
      if (cmd.snapshot) begin
        fcnt_r    <= cnt_r;
        fneg_r    <= sum_r[SW-1];
        fabs_r    <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
        fsq_r     <= sq_r;
        res_count <= cnt_r;
        res_min   <= min_r;
        res_max   <= max_r;
        res_ovf   <= ovf_r;
        res_valid <= cnt_r > COUNT_BITS'(1);
        res_sd    <= '0;
        num_r     <= NW'(cnt_r) * NW'(sq_r);
        den_r     <= DW'(cnt_r) * DW'(cnt_r - 1'b1);
      end
      if (cmd.mean_start) begin
        dn_r    <= NW'({fabs_r, 8'h00});
        dd_r    <= DW'(fcnt_r);
        dq_r    <= '0;
        drem_r  <= '0;
        dcnt_r  <= CW'(NW);
        dbusy_r <= 1'b1;
        dsel_r  <= 1'b0;
        num_r   <= (num_r - NW'(sum_sq)) << 16;
      end else if (cmd.var_start) begin
        dn_r    <= num_r;
        dd_r    <= den_r;
        dq_r    <= '0;
        drem_r  <= '0;
        dcnt_r  <= CW'(NW);
        dbusy_r <= 1'b1;
        dsel_r  <= 1'b1;
      end else if (dbusy_r) begin
        dn_r <= dn_r << 1;
        if (dtry >= {1'b0, dd_r}) begin
          drem_r <= dtry - {1'b0, dd_r};
          dq_r   <= {dq_r[NW-2:0], 1'b1};
        end else begin
          drem_r <= dtry;
          dq_r   <= {dq_r[NW-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
        if (dcnt_r == CW'(1)) begin
          dbusy_r <= 1'b0;
        end
      end
      if (!dbusy_r && dcnt_r == '0 && !cmd.mean_start && !cmd.var_start) begin
        dcnt_r <= '1;
        if (!dsel_r) begin
          res_mean <= fneg_r ? RW'(-dq_r) : RW'(dq_r);
        end
      end
      if (cmd.sqrt_start) begin
        // quotient of the variance always fits 2*RW bits
        rad_r   <= dq_r[2*RW-1:0];
        root_r  <= '0;
        rrem_r  <= '0;
        rcnt_r  <= RCW'(RW);
        rbusy_r <= 1'b1;
      end else if (rbusy_r) begin
        rad_r <= rad_r << 2;
        if (rshift >= rtrial) begin
          rrem_r <= rshift - rtrial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rrem_r <= rshift;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        rcnt_r <= rcnt_r - 1'b1;
        if (rcnt_r == RCW'(1)) begin
          rbusy_r <= 1'b0;
        end
      end
      if (!rbusy_r && rcnt_r == '0 && !cmd.sqrt_start) begin
        rcnt_r <= '1;
        res_sd <= root_r;
      end
    end
  end

  assign sts.div_busy  = dbusy_r || dcnt_r == '0;
  assign sts.sqrt_busy = rbusy_r || rcnt_r == '0;
  assign sts.spread_ok = res_valid;

endmodule

// ----- rtl/ssa_ctrl.sv -----
// controller: sequences accumulation, division and square root
module ssa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ssa_pkg::ssa_cmd_t  cmd,
  input  ssa_pkg::ssa_sts_t  sts
);

  typedef enum logic [2:0] {
    ST_ACC, ST_SNAP, ST_MEAN, ST_VAR, ST_ROOT, ST_SQRT, ST_OUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   wait_r;

  logic take;
  assign in_stall  = state_r != ST_ACC;
  assign take      = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.accumulate = take;
    cmd.snapshot   = state_r == ST_SNAP;
    cmd.mean_start = state_r == ST_MEAN && !wait_r;
    cmd.var_start  = state_r == ST_VAR && !wait_r && !sts.div_busy && sts.spread_ok;
    cmd.sqrt_start = state_r == ST_ROOT && !wait_r && !sts.div_busy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      out_valid_r <= 1'b0;
      wait_r      <= 1'b0;
    end else begin
      wait_r <= 1'b0;
      unique case (state_r)
        ST_ACC: begin
          if (take && in_last) begin
            state_r <= ST_SNAP;
          end
        end
        ST_SNAP: begin
          state_r <= ST_MEAN;
        end
        ST_MEAN: begin
          state_r <= ST_VAR;
          wait_r  <= 1'b1;
        end
        ST_VAR: begin
          if (!wait_r && !sts.div_busy) begin
            if (sts.spread_ok) begin
              state_r <= ST_ROOT;
              wait_r  <= 1'b1;
            end else begin
              state_r     <= ST_OUT;
              out_valid_r <= 1'b1;
            end
          end
        end
        ST_ROOT: begin
          if (!wait_r && !sts.div_busy) begin
            state_r <= ST_SQRT;
            wait_r  <= 1'b1;
          end
        end
        ST_SQRT: begin
          if (!wait_r && !sts.sqrt_busy) begin
            state_r     <= ST_OUT;
            out_valid_r <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!out_stall) begin
            state_r     <= ST_ACC;
            out_valid_r <= 1'b0;
          end
        end
        default: state_r <= ST_ACC;
      endcase
    end
  end

endmodule

// ----- rtl/summary_statistics_accumulator_core.sv -----
// top level of the summary statistics accumulator
//
// channel  direction  handshake           payload
// in_      input      in_valid/in_stall   in_sample, in_last
// out_     output     out_valid/out_stall count, mean, min, max, stddev, flags
//
// samples are taken one per cycle while a set is being gathered
// after the last sample the back part runs: a snapshot, a serial mean division
// and, for sets of more than one sample, a serial variance division and then a
// serial square root
// in_stall stays high from the last transfer until the result transfer
// reset (rst_n low, synchronous) clears the running set and the sequencer
module summary_statistics_accumulator_core #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COUNT_BITS-1:0]         out_sample_count,
  output logic signed [SAMPLE_BITS+7:0] out_mean_fixed,
  output logic signed [SAMPLE_BITS-1:0] out_min_value,
  output logic signed [SAMPLE_BITS-1:0] out_max_value,
  output logic [SAMPLE_BITS+7:0]        out_stddev_fixed,
  output logic                          out_spread_valid,
  output logic                          out_overflow
);

  ssa_pkg::ssa_cmd_t cmd;
  ssa_pkg::ssa_sts_t sts;

  // sequencer
  ssa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_last   (in_last),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // accumulators and arithmetic units
  ssa_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .sample    (in_sample),
    .res_count (out_sample_count),
    .res_mean  (out_mean_fixed),
    .res_min   (out_min_value),
    .res_max   (out_max_value),
    .res_sd    (out_stddev_fixed),
    .res_valid (out_spread_valid),
    .res_ovf   (out_overflow)
  );

endmodule

// ----- rtl/ssa_checker.sv -----
// port level checks for the summary statistics accumulator
module ssa_checker #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input logic                   in_last,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [COUNT_BITS-1:0]  out_sample_count,
  input logic [SAMPLE_BITS+7:0] out_stddev_fixed,
  input logic                   out_spread_valid
);

  // a result never appears while samples are still being taken
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("result shown while taking samples");

  // last transfer closes the input side
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall) else $error("input open after last");

  // single sample set has no spread
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_sample_count == COUNT_BITS'(1)) |-> (!out_spread_valid &&
      out_stddev_fixed == '0)) else $error("spread on single sample");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_sample_count)))
    else $error("stalled result changed");

endmodule

bind summary_statistics_accumulator_core ssa_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .COUNT_BITS  (COUNT_BITS)
) u_ssa_checker (.*);

// ----- tb/tb_summary_statistics_accumulator_core.sv -----
// self-checking testbench for the summary statistics accumulator core
`timescale 1ns / 100ps

module tb_summary_statistics_accumulator_core;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam int STALL_LIMIT = 4000;   // cycles with no transfer on either side
  localparam int TAIL_CYCLES = 400;    // idle cycles after the last set has drained

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } sample_xfer_t;

  typedef struct {
    logic [COUNT_BITS-1:0]         sample_count;
    logic signed [SAMPLE_BITS+7:0] mean_fixed;
    logic signed [SAMPLE_BITS-1:0] min_value;
    logic signed [SAMPLE_BITS-1:0] max_value;
    logic [SAMPLE_BITS+7:0]        stddev_fixed;
    logic                          spread_valid;
    logic                          overflow;
  } set_summary_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic                          in_last;
  logic                          out_valid;
  logic                          out_stall;
  logic [COUNT_BITS-1:0]         out_sample_count;
  logic signed [SAMPLE_BITS+7:0] out_mean_fixed;
  logic signed [SAMPLE_BITS-1:0] out_min_value;
  logic signed [SAMPLE_BITS-1:0] out_max_value;
  logic [SAMPLE_BITS+7:0]        out_stddev_fixed;
  logic                          out_spread_valid;
  logic                          out_overflow;

  sample_xfer_t pending_samples[$];
  set_summary_t expected_summaries[$];

  int sender_idle_pct;
  int receiver_stall_pct;
  int error_count;
  int samples_sent;
  int summaries_checked;
  int quiet_cycles;

  // running set as the predictor sees it
  longint                        set_count;
  longint                        set_sum;
  logic [127:0]                  set_sum_sq;
  logic signed [SAMPLE_BITS-1:0] set_min;
  logic signed [SAMPLE_BITS-1:0] set_max;
  bit                            set_overflowed;

  summary_statistics_accumulator_core #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_sample       (in_sample),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_sample_count(out_sample_count),
    .out_mean_fixed  (out_mean_fixed),
    .out_min_value   (out_min_value),
    .out_max_value   (out_max_value),
    .out_stddev_fixed(out_stddev_fixed),
    .out_spread_valid(out_spread_valid),
    .out_overflow    (out_overflow)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor of the square root, one result bit per step
  function automatic logic [127:0] floor_sqrt(logic [127:0] radicand);
    logic [127:0] root;
    logic [127:0] trial;
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      trial = root | (128'd1 << i);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_running_set();
    set_count      = 0;
    set_sum        = 0;
    set_sum_sq     = '0;
    set_min        = '0;
    set_max        = '0;
    set_overflowed = 1'b0;
  endfunction

  // fold one accepted sample into the running set; on the last one queue the summary
  function automatic void fold_sample(logic signed [SAMPLE_BITS-1:0] sample, logic last);
    longint       value;
    longint       abs_sum;
    longint       mean_mag;
    logic [127:0] spread_num;
    logic [127:0] spread_den;
    set_summary_t summary;
    value = sample;
    if (set_count == 0) begin
      set_min = sample;
      set_max = sample;
    end else if (sample < set_min) begin
      set_min = sample;
    end else if (sample > set_max) begin
      set_max = sample;
    end
    // saturated count: sample still moves min and max and sets the overflow flag, nothing else
    if (set_count >= COUNT_MAX) begin
      set_overflowed = 1'b1;
    end else begin
      set_count  = set_count + 1;
      set_sum    = set_sum + value;
      set_sum_sq = set_sum_sq + 128'(value * value);
    end
    if (!last) return;
    abs_sum  = (set_sum < 0) ? -set_sum : set_sum;
    mean_mag = (abs_sum * 256) / set_count;
    summary.sample_count = set_count[COUNT_BITS-1:0];
    summary.mean_fixed   = (SAMPLE_BITS+8)'((set_sum < 0) ? -mean_mag : mean_mag);
    summary.min_value    = set_min;
    summary.max_value    = set_max;
    summary.spread_valid = (set_count > 1);
    summary.overflow     = set_overflowed;
    summary.stddev_fixed = '0;
    if (set_count > 1) begin
      spread_num = 128'(set_count) * set_sum_sq - 128'(abs_sum) * 128'(abs_sum);
      spread_num = spread_num << 16;
      spread_den = 128'(set_count) * 128'(set_count - 1);
      summary.stddev_fixed = (SAMPLE_BITS+8)'(floor_sqrt(spread_num / spread_den));
    end
    expected_summaries.push_back(summary);
    clear_running_set();
  endfunction

  // driver: payload is held while a stalled transfer is outstanding
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      in_sample <= '0;
      in_last   <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        fold_sample(in_sample, in_last);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() == 0 || $urandom_range(99) < sender_idle_pct) begin
          in_valid <= 1'b0;
        end else begin
          sample_xfer_t next_xfer;
          next_xfer = pending_samples.pop_front();
          in_valid  <= 1'b1;
          in_sample <= next_xfer.sample;
          in_last   <= next_xfer.last;
        end
      end
    end
  end

  // monitor: compares each result transfer with the oldest expected summary
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (out_valid && !out_stall) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: result transfer with nothing expected (count %0d)",
                   $time, out_sample_count);
          error_count++;
        end else begin
          set_summary_t exp_s;
          exp_s = expected_summaries.pop_front();
          summaries_checked++;
          if (out_sample_count !== exp_s.sample_count) begin
            $display("%0t: sample_count expected %0d actual %0d", $time,
                     exp_s.sample_count, out_sample_count);
            error_count++;
          end
          if (out_mean_fixed !== exp_s.mean_fixed) begin
            $display("%0t: mean_fixed expected %0d actual %0d", $time,
                     exp_s.mean_fixed, out_mean_fixed);
            error_count++;
          end
          if (out_min_value !== exp_s.min_value) begin
            $display("%0t: min_value expected %0d actual %0d", $time,
                     exp_s.min_value, out_min_value);
            error_count++;
          end
          if (out_max_value !== exp_s.max_value) begin
            $display("%0t: max_value expected %0d actual %0d", $time,
                     exp_s.max_value, out_max_value);
            error_count++;
          end
          if (out_stddev_fixed !== exp_s.stddev_fixed) begin
            $display("%0t: stddev_fixed expected %0d actual %0d", $time,
                     exp_s.stddev_fixed, out_stddev_fixed);
            error_count++;
          end
          if (out_spread_valid !== exp_s.spread_valid) begin
            $display("%0t: spread_valid expected %0d actual %0d", $time,
                     exp_s.spread_valid, out_spread_valid);
            error_count++;
          end
          if (out_overflow !== exp_s.overflow) begin
            $display("%0t: overflow expected %0d actual %0d", $time,
                     exp_s.overflow, out_overflow);
            error_count++;
          end
        end
      end
    end
  end

  // watchdog: any transfer on either side resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb_summary_statistics_accumulator_core: errors");
        $finish;
      end
    end
  end

  task automatic queue_sample(logic signed [SAMPLE_BITS-1:0] sample, logic last);
    sample_xfer_t x;
    x.sample = sample;
    x.last   = last;
    pending_samples.push_back(x);
  endtask

  // a set of n copies of one value, with last set on the final copy
  task automatic queue_constant_set(int n, logic signed [SAMPLE_BITS-1:0] value);
    for (int i = 0; i < n; i++) queue_sample(value, i == n - 1);
  endtask

  // random sets: mostly short, value spread picked per set
  task automatic queue_random_sets(int n_samples);
    int queued;
    int set_len;
    int spread;
    logic signed [SAMPLE_BITS-1:0] value;
    queued = 0;
    while (queued < n_samples) begin
      set_len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(12, 1);
      spread  = $urandom_range(3);
      for (int i = 0; i < set_len; i++) begin
        case (spread)
          0: value = 16'($urandom);                          // full range
          1: value = 16'(int'($urandom_range(15)) - 8);      // near zero
          2: value = $urandom_range(1) ? 16'h7fff : 16'h8000; // extremes
          default: value = 16'($urandom_range(2000)) + 16'sd30000;
        endcase
        queue_sample(value, i == set_len - 1);
      end
      queued += set_len;
    end
  endtask

  task automatic wait_for_drain();
    while (pending_samples.size() != 0 || in_valid || expected_summaries.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n              = 1'b0;
    sender_idle_pct    = 10;
    receiver_stall_pct = 76;
    error_count        = 0;
    samples_sent       = 0;
    summaries_checked  = 0;
    clear_running_set();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single samples, extremes, zero spread, negative truncation
    queue_sample(16'sh8000, 1'b1);
    queue_sample(16'sh7fff, 1'b1);
    queue_sample(16'sh0000, 1'b1);
    queue_sample(16'sh8000, 1'b0);
    queue_sample(16'sh7fff, 1'b1);
    queue_constant_set(3, 16'sh1234);
    queue_sample(-16'sd1, 1'b0);
    queue_sample(16'sd0, 1'b0);
    queue_sample(16'sd0, 1'b1);
    queue_sample(16'sd1, 1'b0);
    queue_sample(16'sd2, 1'b1);
    queue_sample(16'sd5, 1'b0);
    queue_sample(-16'sd3, 1'b0);
    queue_sample(16'sh5555, 1'b0);
    queue_sample(16'shaaaa, 1'b1);
    queue_random_sets(400);
    wait_for_drain();

    // sender held until every summary is back, then the idling swaps
    sender_idle_pct    = 76;
    receiver_stall_pct = 10;
    queue_random_sets(400);
    wait_for_drain();

    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    queue_random_sets(400);
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d samples and %0d set summaries, incl. single-sample sets,",
             samples_sent, summaries_checked);
    $display("full-scale extremes, near-zero and long mixed-sign sets");
    if (error_count == 0) begin
      $display("tb_summary_statistics_accumulator_core: clean");
    end else begin
      $display("tb_summary_statistics_accumulator_core: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/ssa_pkg.sv
rtl/ssa_datapath.sv
rtl/ssa_ctrl.sv
rtl/summary_statistics_accumulator_core.sv
rtl/ssa_checker.sv
tb/tb_summary_statistics_accumulator_core.sv
